>>> hdl/square_matrix_multiply_assert.svh
// ----------------------------------------------------------------------------
// square_matrix_multiply_assert.svh - assertion macros
// Shared macros for the concurrent checks of the matrix multiplier.
// ----------------------------------------------------------------------------
`ifndef SQUARE_MATRIX_MULTIPLY_ASSERT_SVH
`define SQUARE_MATRIX_MULTIPLY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg - shared types and constants
// Word widths and the buses that run along the chain of multiply cells.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int DATA_W      = 32;
  localparam int IDX_W       = 3;
  localparam int SIZE_W      = 4;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  // Operand word passed from one cell to the next.
  typedef struct packed {
    logic              vld;
    logic              first;
    logic              last;
    logic [IDX_W-1:0]  k;
    logic [DATA_W-1:0] a;
  } cell_bus_t;

  // Write of one B element into the column held by a cell.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] data;
  } bwr_t;

  // Product stage status reported by a cell.
  typedef struct packed {
    logic p_vld;
    logic p_last;
  } cell_stat_t;

endpackage

>>> hdl/square_matrix_multiply.sv
// Loads n*n word pairs, one per cycle while tready is high; words are not taken during compute.
// Per row of C: the n A words are issued from the store and pass through the cell chain, then
// n output words leave at one per cycle unless the sink stalls; rows run one by one.
// Reset (rst, synchronous, active high) clears control and sets matrix_size to 8.
// Operand stores are not cleared; only entries written in the current load are read.
// ----------------------------------------------------------------------------
// square_matrix_multiply - square integer matrix multiplier
// Collects A and B in row-major order, then computes C = A * B one row at a
// time on a chain of multiply-accumulate cells and streams C out row-major.
// ----------------------------------------------------------------------------
module square_matrix_multiply
  import smm_pkg::*;
#(
  parameter int MAX_SIZE = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration: matrix_size
  input  logic                   cfg_wen,
  input  logic [SIZE_W-1:0]      cfg_wdata,
  // Input words
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] a_value, [63:32] b_value
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Output words
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [2:0] out_row, [5:3] out_col, [37:6] product_value, [39:38] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

`include "square_matrix_multiply_assert.svh"

  localparam int KW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]        state;
  logic [SIZE_W-1:0] size_q;
  logic [KW-1:0]     n_m1;
  logic [KW-1:0]     ld_row;
  logic [KW-1:0]     ld_col;
  logic [AW-1:0]     ld_addr;
  logic [AW-1:0]     rd_addr;
  logic [KW-1:0]     k_cnt;
  logic [KW-1:0]     row_i;
  logic [KW-1:0]     drain_col;
  logic              iss_vld;
  logic              iss_first;
  logic              iss_last;
  logic [KW-1:0]     iss_k;
  logic [DATA_W-1:0] ram_rd_data;
  logic              in_acc;
  logic              load_last;
  logic              out_load;
  logic              m_valid;
  logic [IDX_W-1:0]  out_row_q;
  logic [IDX_W-1:0]  out_col_q;
  logic [DATA_W-1:0] out_val_q;
  logic              out_last_q;
  bwr_t              bwr;
  cell_bus_t         chain [MAX_SIZE+1];
  logic [DATA_W-1:0] acc    [MAX_SIZE+1];
  cell_stat_t        stat   [MAX_SIZE];

  // Effective size minus one: zero acts as one, oversize clamps.
  always_comb begin
    if (size_q == '0) begin
      n_m1 = '0;
    end else if (size_q > SIZE_W'(MAX_SIZE)) begin
      n_m1 = KW'(MAX_SIZE - 1);
    end else begin
      n_m1 = KW'(size_q - SIZE_W'(1));
    end
  end

  assign s_axis_tready = (state == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load_last     = (ld_row == n_m1) && (ld_col == n_m1);
  assign out_load      = (state == ST_DRAIN) && (!m_valid || m_axis_tready);

  // A store.
  smm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (ld_addr),
    .wr_data (s_axis_tdata[DATA_W-1:0]),
    .rd_en   (state == ST_ISSUE),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  // B elements go to the cell that owns their column.
  assign bwr = '{en:   in_acc,
                 row:  IDX_W'(ld_row),
                 col:  IDX_W'(ld_col),
                 data: s_axis_tdata[2*DATA_W-1:DATA_W]};

  // Head of the chain: A word from memory with its issue tag.
  assign chain[0] = '{vld:   iss_vld,
                      first: iss_first,
                      last:  iss_last,
                      k:     IDX_W'(iss_k),
                      a:     ram_rd_data};
  assign acc[MAX_SIZE] = '0;

  // Row of multiply-accumulate cells.
  for (genvar j = 0; j < MAX_SIZE; j++) begin : g_cell
    smm_cell #(
      .MAX_SIZE (MAX_SIZE),
      .CELL_IDX (j)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .bwr      (bwr),
      .din      (chain[j]),
      .dout     (chain[j+1]),
      .shift_en (out_load),
      .shift_in (acc[j+1]),
      .acc_out  (acc[j]),
      .stat     (stat[j])
    );
  end

  // Sequencer: load, issue one row, wait for the chain, drain the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      size_q    <= SIZE_W'(8);
      ld_row    <= '0;
      ld_col    <= '0;
      ld_addr   <= '0;
      rd_addr   <= '0;
      k_cnt     <= '0;
      row_i     <= '0;
      drain_col <= '0;
      iss_vld   <= 1'b0;
    end else begin
      iss_vld <= 1'b0;
      if (cfg_wen) begin
        size_q  <= cfg_wdata;
        ld_row  <= '0;
        ld_col  <= '0;
        ld_addr <= '0;
      end
      case (state)
        ST_LOAD: begin
          if (in_acc && !cfg_wen) begin
            if (load_last) begin
              ld_row  <= '0;
              ld_col  <= '0;
              ld_addr <= '0;
              rd_addr <= '0;
              k_cnt   <= '0;
              row_i   <= '0;
              state   <= ST_ISSUE;
            end else begin
              ld_addr <= ld_addr + AW'(1);
              if (ld_col == n_m1) begin
                ld_col <= '0;
                ld_row <= ld_row + KW'(1);
              end else begin
                ld_col <= ld_col + KW'(1);
              end
            end
          end
        end
        ST_ISSUE: begin
          iss_vld <= 1'b1;
          rd_addr <= rd_addr + AW'(1);
          if (k_cnt == n_m1) begin
            k_cnt <= '0;
            state <= ST_WAIT;
          end else begin
            k_cnt <= k_cnt + KW'(1);
          end
        end
        ST_WAIT: begin
          if (stat[MAX_SIZE-1].p_vld && stat[MAX_SIZE-1].p_last) begin
            drain_col <= '0;
            state     <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            drain_col <= drain_col + KW'(1);
            if (drain_col == n_m1) begin
              if (row_i == n_m1) begin
                state <= ST_LOAD;
              end else begin
                row_i <= row_i + KW'(1);
                state <= ST_ISSUE;
              end
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Issue tag that travels with the registered memory read.
  always_ff @(posedge clk) begin
    iss_k     <= k_cnt;
    iss_first <= (k_cnt == '0);
    iss_last  <= (k_cnt == n_m1);
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (out_load) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  // Output register payload, taken from the cell at the head of the chain.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_q  <= IDX_W'(row_i);
      out_col_q  <= IDX_W'(drain_col);
      out_val_q  <= acc[0];
      out_last_q <= (row_i == n_m1) && (drain_col == n_m1);
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_val_q, out_col_q, out_row_q};

  // Checks on the sequencer and the chain.
  `SMM_ASSERT_NEXT(a_issue_feeds_chain, clk, rst, state == ST_ISSUE, iss_vld,
                   "issue cycle did not launch a word")
  `SMM_ASSERT_SAME(a_chain_busy_only_in_compute, clk, rst, stat[MAX_SIZE-1].p_vld,
                   (state == ST_ISSUE) || (state == ST_WAIT), "chain active outside compute")
  `SMM_ASSERT_NEXT(a_cfg_restarts_load, clk, rst, cfg_wen,
                   (ld_addr == '0) && (ld_row == '0) && (ld_col == '0),
                   "size write did not restart loading")

endmodule

>>> hdl/smm_ram.sv
// ----------------------------------------------------------------------------
// smm_ram - generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [2**AW];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/smm_cell.sv
// ----------------------------------------------------------------------------
// smm_cell - one multiply-accumulate cell of the chain
// Holds one column of B, multiplies the passing A word by B[k][col], and
// accumulates one element of the current row of C. Results leave through
// a shift path toward cell zero.
// ----------------------------------------------------------------------------
module smm_cell
  import smm_pkg::*;
#(
  parameter int MAX_SIZE = 8,
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  bwr_t              bwr,
  input  cell_bus_t         din,
  output cell_bus_t         dout,
  input  logic              shift_en,
  input  logic [DATA_W-1:0] shift_in,
  output logic [DATA_W-1:0] acc_out,
  output cell_stat_t        stat
);

  localparam int KW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  logic [DATA_W-1:0] bcol [2**KW];
  logic [KW-1:0]     wr_k;
  logic [KW-1:0]     rd_k;
  logic              p_vld;
  logic              p_first;
  logic              p_last;
  logic [DATA_W-1:0] p_val;
  logic [DATA_W-1:0] acc;

  assign wr_k = bwr.row[KW-1:0];
  assign rd_k = din.k[KW-1:0];

  // Column store: takes the B elements that fall in this column.
  always_ff @(posedge clk) begin
    if (bwr.en && (bwr.col == IDX_W'(CELL_IDX))) begin
      bcol[wr_k] <= bwr.data;
    end
  end

  // Forward the operand word to the neighbor; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.first <= din.first;
    dout.last  <= din.last;
    dout.k     <= din.k;
    dout.a     <= din.a;
  end

  // Product stage: low 32 bits of A times B, same for signed and unsigned.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= din.vld;
    end
  end

  always_ff @(posedge clk) begin
    p_first <= din.first;
    p_last  <= din.last;
    p_val   <= din.a * bcol[rd_k];
  end

  // Accumulator, reused as a shift register while the row drains.
  always_ff @(posedge clk) begin
    if (p_vld) begin
      acc <= p_first ? p_val : acc + p_val;
    end else if (shift_en) begin
      acc <= shift_in;
    end
  end

  assign acc_out = acc;
  assign stat    = '{p_vld: p_vld, p_last: p_last};

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - testbench for square_matrix_multiply
// Streams pairs of A and B elements into the multiplier and checks every
// product word against a matrix product computed here from the same pairs.
// The run covers sizes zero, one, two and the full size directly, other sizes at random, out-of-range size
// settings and abandoned loads, with random gaps on the input and stalls on the output.
// ---------------------------------------------------------------------------
module tb;
  import smm_pkg::*;

  localparam int MAX_DIM = 8;
  localparam int STORE_DEPTH = 64;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS = 430;
  localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  // Output stall patterns of the sink.
  typedef enum int {RX_FREE, RX_COIN, RX_HEAVY, RX_CADENCE} rx_mode_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              last;
  } product_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wen = 1'b0;
  logic [SIZE_W-1:0]      cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [31:0] a_value, [63:32] b_value
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [2:0] out_row, [5:3] out_col, [37:6] product_value, [39:38] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  // Mirror of the operand stores and the load position.
  logic [DATA_W-1:0] a_store [STORE_DEPTH];
  logic [DATA_W-1:0] b_store [STORE_DEPTH];
  int unsigned       pairs_loaded = 0;
  logic [SIZE_W-1:0] size_reg = 4'd8;

  product_t              product_q [$];
  logic [IN_TDATA_W-1:0] pair_q [$];
  int                    fail_count = 0;
  logic                  in_taken = 1'b0;

  int       src_gap = 0;
  int       src_burst = 0;
  rx_mode_t rx_mode = RX_FREE;
  int       rx_span = 0;
  int       cycle_no = 0;

  square_matrix_multiply #(
    .MAX_SIZE(MAX_DIM)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A size of zero behaves as one, and sizes above the maximum are clamped.
  function automatic int active_dim(input logic [SIZE_W-1:0] setting);
    int n;
    n = int'(setting);
    if (n == 0) n = 1;
    if (n > MAX_DIM) n = MAX_DIM;
    return n;
  endfunction

  // Store one pair; when the load is complete, queue the whole product row-major.
  task automatic load_pair(input logic [IN_TDATA_W-1:0] word);
    int n;
    logic [DATA_W-1:0] acc;
    product_t p;
    n = active_dim(size_reg);
    a_store[pairs_loaded % STORE_DEPTH] = word[DATA_W-1:0];
    b_store[pairs_loaded % STORE_DEPTH] = word[IN_TDATA_W-1:DATA_W];
    pairs_loaded = (pairs_loaded + 1) % 128;
    if (pairs_loaded >= n * n) begin
      pairs_loaded = 0;
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          acc = '0;
          for (int k = 0; k < n; k++) begin
            acc = acc + a_store[(i * n + k) % STORE_DEPTH] *
                        b_store[(k * n + j) % STORE_DEPTH];
          end
          p.row = IDX_W'(i);
          p.col = IDX_W'(j);
          p.value = acc;
          p.last = (i == n - 1) && (j == n - 1);
          product_q.push_back(p);
        end
      end
    end
  endtask

  task automatic note_failure(input string msg);
    if (fail_count < 10) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  // Compare one output word with the oldest product still owed.
  task automatic check_word();
    product_t got;
    product_t want;
    got.row = m_axis_tdata[IDX_W-1:0];
    got.col = m_axis_tdata[2*IDX_W-1:IDX_W];
    got.value = m_axis_tdata[2*IDX_W+DATA_W-1:2*IDX_W];
    got.last = m_axis_tlast;
    if (product_q.size() == 0) begin
      note_failure($sformatf("word with no product owed: row %0d col %0d value %0d last %0b",
                             got.row, got.col, $signed(got.value), got.last));
    end else begin
      want = product_q.pop_front();
      if (got.row !== want.row || got.col !== want.col ||
          got.value !== want.value || got.last !== want.last) begin
        note_failure($sformatf(
          "expected row %0d col %0d value %0d last %0b, got row %0d col %0d value %0d last %0b",
          want.row, want.col, $signed(want.value), want.last,
          got.row, got.col, $signed(got.value), got.last));
      end
    end
  endtask

  // Sample both handshakes and the size write at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
      size_reg = 4'd8;
      pairs_loaded = 0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) check_word();
      if (cfg_wen) begin
        size_reg = cfg_wdata;
        pairs_loaded = 0;
      end
      if (s_axis_tvalid && s_axis_tready) load_pair(s_axis_tdata);
    end
  end

  // Input driver: presents queued pairs in bursts separated by idle gaps.
  always @(negedge clk) begin : source
    logic                  next_valid;
    logic [IN_TDATA_W-1:0] next_data;
    next_valid = s_axis_tvalid;
    next_data = s_axis_tdata;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (s_axis_tvalid && in_taken) next_valid = 1'b0;
      if (!next_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pair_q.size() != 0) begin
          next_data = pair_q.pop_front();
          next_valid = 1'b1;
          if (src_burst > 0) begin
            src_burst--;
          end else begin
            src_burst = $urandom_range(1, 40);
            src_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
    s_axis_tvalid <= next_valid;
    s_axis_tdata <= next_data;
  end

  // Output sink: switches at random between stall patterns.
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_span = $urandom_range(20, 200);
    end
    rx_span--;
    cycle_no++;
    case (rx_mode)
      RX_FREE:  m_axis_tready <= 1'b1;
      RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
      RX_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:  m_axis_tready <= ((cycle_no % 8) < 5);
    endcase
  end

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 11))
      0:       v = MOST_NEG;
      1:       v = MOST_POS;
      2:       v = ALL_ONES;
      3:       v = '0;
      4:       v = DATA_W'($urandom_range(0, 15));
      5:       v = '0 - DATA_W'($urandom_range(1, 15));
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic void queue_pair(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    pair_q.push_back({b, a});
  endfunction

  function automatic void queue_load(input int count);
    repeat (count) queue_pair(pick_value(), pick_value());
  endfunction

  // Wait until every pair is taken and every product has come out, then let
  // the block finish any work that produces no word.
  task automatic wait_idle();
    while (pair_q.size() != 0 || s_axis_tvalid || product_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] setting);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= setting;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin : stimulus
    int random_items;
    int phase;
    int setting;
    int n;
    int loads;
    int partial;
    random_items = 0;
    phase = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // One full 8x8 load at the reset size.
    queue_load(MAX_DIM * MAX_DIM);
    random_items += MAX_DIM * MAX_DIM;
    wait_idle();

    // Size zero acts as one: each pair is a whole matrix.
    write_size(4'd0);
    queue_pair(MOST_NEG, MOST_NEG);
    queue_pair(MOST_POS, MOST_POS);
    queue_pair(ALL_ONES, MOST_NEG);
    wait_idle();

    // A 2x2 product built from the extreme values.
    write_size(4'd2);
    queue_pair(MOST_POS, MOST_POS);
    queue_pair(MOST_NEG, 32'd1);
    queue_pair(ALL_ONES, ALL_ONES);
    queue_pair('0, MOST_NEG);
    wait_idle();

    // Abandon a 3x3 load halfway; the size write must restart loading.
    write_size(4'd3);
    queue_load(5);
    wait_idle();
    write_size(4'd1);
    queue_pair(MOST_POS, ALL_ONES);
    wait_idle();

    // Random phases: mostly small sizes, the clamped settings first.
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 0) setting = 15;
      else if (phase == 1) setting = 9;
      else if ($urandom_range(0, 9) < 7) setting = $urandom_range(1, 4);
      else setting = $urandom_range(0, 15);
      write_size(SIZE_W'(setting));
      n = active_dim(SIZE_W'(setting));
      loads = (n >= 6) ? 1 : $urandom_range(1, 4);
      repeat (loads) queue_load(n * n);
      random_items += loads * n * n;
      // Now and then leave a load unfinished before the next size write.
      if (n > 1 && $urandom_range(0, 5) == 0) begin
        partial = $urandom_range(1, n * n - 1);
        queue_load(partial);
        random_items += partial;
      end
      phase++;
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
